@@ hw/rtl/sbb_pkg.sv @@
// sbb_pkg: shared types and constants for the separable box blur core.
// Used by the controller, the datapath, the divider and the top level.
package sbb_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int PIX_W      = 8;   // pixel width
  localparam int SIZE_CFG_W = 7;   // image_width / image_height register width
  localparam int KS_W       = 5;   // kernel_size register width
  localparam int RAD_W      = KS_W - 1;
  localparam int CNT_W      = 5;   // in-bounds tap count, at most 31
  localparam int SUM_W      = PIX_W + CNT_W;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  // register index, paddr[3:2]
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;

  localparam logic [SIZE_CFG_W-1:0] RST_IMAGE_WIDTH  = 7'd64;
  localparam logic [SIZE_CFG_W-1:0] RST_IMAGE_HEIGHT = 7'd64;
  localparam logic [KS_W-1:0]       RST_KERNEL_SIZE  = 5'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DRAIN,
    DP_EMIT,
    DP_INIT,
    DP_SETUP,
    DP_MUL,
    DP_ACC,
    DP_DIVGO,
    DP_WRITE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   vpass;   // 1 during the column pass
  } dp_cmd_t;

  typedef struct packed {
    logic load_last;  // current load completes the frame
    logic acc_done;   // window sum finished
    logic div_busy;
    logic pix_last;   // pass position is the last pixel
  } dp_status_t;

endpackage

@@ hw/rtl/sbb_div.sv @@
// sbb_div: restoring divider, one quotient bit per cycle, for the window mean.
// Depends on sbb_pkg for SUM_W, CNT_W and PIX_W.
module sbb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sbb_pkg::SUM_W-1:0] dividend,
  input  logic [sbb_pkg::CNT_W-1:0] divisor,
  output logic                      busy,
  output logic [sbb_pkg::PIX_W-1:0] quotient
);
  import sbb_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic [CNT_W:0]    trial;

  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CNT_W'(trial - {1'b0, div_r});
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = CNT_W'(trial);
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      step_r <= STEP_W'(SUM_W);
    end else if (run_r) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = run_r;
  assign quotient = quo_r[PIX_W-1:0];

endmodule

@@ hw/rtl/sbb_datapath.sv @@
// sbb_datapath: pixel stores, pointers, window address/sum logic and result registers.
// Depends on sbb_pkg and sbb_div; driven by commands from sbb_ctrl.
module sbb_datapath #(
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbb_pkg::dp_cmd_t               cmd,
  output sbb_pkg::dp_status_t            st,
  input  logic [sbb_pkg::SIZE_CFG_W-1:0] cfg_width,
  input  logic [sbb_pkg::SIZE_CFG_W-1:0] cfg_height,
  input  logic [sbb_pkg::KS_W-1:0]       cfg_kernel,
  input  logic [sbb_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                           out_valid,
  output logic [sbb_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_last_pixel,
  output logic                           out_not_ready
);
  import sbb_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int MAX_D  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W  = $clog2(MAX_D + 1);
  localparam int E_W    = ((DIM_W > RAD_W + 1) ? DIM_W : RAD_W + 1) + 1;

  logic [PIX_W-1:0] src_mem [DEPTH];
  logic [PIX_W-1:0] row_mem [DEPTH];
  logic [PIX_W-1:0] res_mem [DEPTH];
  logic [PIX_W-1:0] src_q_r, row_q_r, res_q_r;

  logic [DIM_W-1:0]  w_c, h_c;
  logic [SIZE_W-1:0] size;
  logic [RAD_W-1:0]  rad;

  logic [SIZE_W-1:0] load_ptr_r, load_inc;
  logic [ADDR_W-1:0] drain_ptr_r, drain_eff;
  logic [SIZE_W-1:0] drain_inc;
  logic              drain_is_last;
  logic              frame_ready_r;
  logic              drain_last_r, drain_nr_r;

  logic [DIM_W-1:0]   x_r, y_r;
  logic [ADDR_W-1:0]  pix_r;
  logic [DIM_W-1:0]   lo_r;
  logic [CNT_W-1:0]   cnt_r, issue_left_r;
  logic [ADDR_W-1:0]  rd_addr_r, start_addr, stride;
  logic               rd_valid_r, rd_en;
  logic [SUM_W-1:0]   sum_r;
  logic [PIX_W-1:0]   acc_data;
  logic [2*DIM_W-1:0] col_off;

  logic [E_W-1:0] p_e, n_e, r_e, lo_e, top_e, last_e, hi_e, cnt_e;

  logic             div_busy;
  logic [PIX_W-1:0] div_q;

  logic              out_valid_r, out_last_r, out_nr_r;
  logic [PIX_W-1:0]  out_pixel_r;

  // size registers saturate into the supported range
  always_comb begin
    if (cfg_width == '0)                 w_c = DIM_W'(1);
    else if (int'(cfg_width) > MAX_WIDTH) w_c = DIM_W'(MAX_WIDTH);
    else                                  w_c = DIM_W'(cfg_width);
    if (cfg_height == '0)                  h_c = DIM_W'(1);
    else if (int'(cfg_height) > MAX_HEIGHT) h_c = DIM_W'(MAX_HEIGHT);
    else                                    h_c = DIM_W'(cfg_height);
  end

  assign size = SIZE_W'(w_c) * SIZE_W'(h_c);
  assign rad  = cfg_kernel[KS_W-1:1];

  assign load_inc      = load_ptr_r + SIZE_W'(1);
  assign drain_eff     = (SIZE_W'(drain_ptr_r) >= size) ? '0 : drain_ptr_r;
  assign drain_inc     = SIZE_W'(drain_eff) + SIZE_W'(1);
  assign drain_is_last = (drain_inc >= size);

  // clipped window bounds around the current row or column position
  always_comb begin
    p_e    = E_W'(cmd.vpass ? y_r : x_r);
    n_e    = E_W'(cmd.vpass ? h_c : w_c);
    r_e    = E_W'(rad);
    lo_e   = (p_e > r_e) ? (p_e - r_e) : '0;
    top_e  = p_e + r_e;
    last_e = n_e - E_W'(1);
    hi_e   = (top_e < last_e) ? top_e : last_e;
    cnt_e  = hi_e - lo_e + E_W'(1);
  end

  assign col_off    = (2*DIM_W)'(lo_r) * (2*DIM_W)'(w_c);
  assign start_addr = cmd.vpass ? (ADDR_W'(x_r) + ADDR_W'(col_off))
                                : (pix_r - ADDR_W'(x_r) + ADDR_W'(lo_r));
  assign stride     = cmd.vpass ? ADDR_W'(w_c) : ADDR_W'(1);
  assign rd_en      = (cmd.op == DP_ACC) && (issue_left_r != '0);
  assign acc_data   = cmd.vpass ? row_q_r : src_q_r;

  // stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD && load_ptr_r < SIZE_W'(DEPTH))
      src_mem[load_ptr_r[ADDR_W-1:0]] <= in_pixel_in;
    if (rd_en && !cmd.vpass) src_q_r <= src_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_WRITE && !cmd.vpass) row_mem[pix_r] <= div_q;
    if (rd_en && cmd.vpass) row_q_r <= row_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_WRITE && cmd.vpass) res_mem[pix_r] <= div_q;
    if (cmd.op == DP_DRAIN) res_q_r <= res_mem[drain_eff];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r    <= '0;
      drain_ptr_r   <= '0;
      frame_ready_r <= 1'b0;
      rd_valid_r    <= 1'b0;
      issue_left_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_valid_r  <= rd_en;
      out_valid_r <= (cmd.op == DP_EMIT);
      case (cmd.op)
        DP_LOAD: begin
          if (load_inc >= size) begin
            load_ptr_r    <= '0;
            drain_ptr_r   <= '0;
            frame_ready_r <= 1'b1;
          end else begin
            load_ptr_r <= load_inc;
          end
        end
        DP_DRAIN: begin
          if (frame_ready_r)
            drain_ptr_r <= drain_is_last ? '0 : ADDR_W'(drain_inc);
        end
        DP_MUL:  issue_left_r <= cnt_r;
        DP_ACC:  if (rd_en) issue_left_r <= issue_left_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // pass position, window and result payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_DRAIN: begin
        drain_last_r <= frame_ready_r && drain_is_last;
        drain_nr_r   <= !frame_ready_r;
      end
      DP_EMIT: begin
        out_pixel_r <= drain_nr_r ? '0 : res_q_r;
        out_last_r  <= drain_last_r;
        out_nr_r    <= drain_nr_r;
      end
      DP_INIT: begin
        x_r   <= '0;
        y_r   <= '0;
        pix_r <= '0;
      end
      DP_SETUP: begin
        lo_r  <= DIM_W'(lo_e);
        cnt_r <= CNT_W'(cnt_e);
        sum_r <= '0;
      end
      DP_MUL: rd_addr_r <= start_addr;
      DP_ACC: begin
        if (rd_en) rd_addr_r <= rd_addr_r + stride;
        if (rd_valid_r) sum_r <= sum_r + SUM_W'(acc_data);
      end
      DP_WRITE: begin
        pix_r <= pix_r + ADDR_W'(1);
        if (x_r == w_c - DIM_W'(1)) begin
          x_r <= '0;
          y_r <= y_r + DIM_W'(1);
        end else begin
          x_r <= x_r + DIM_W'(1);
        end
      end
      default: ;
    endcase
  end

  sbb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == DP_DIVGO),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign st.load_last = (load_inc >= size);
  assign st.acc_done  = (issue_left_r == '0) && !rd_valid_r;
  assign st.div_busy  = div_busy;
  assign st.pix_last  = (x_r == w_c - DIM_W'(1)) && (y_r == h_c - DIM_W'(1));

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_last_pixel = out_last_r;
  assign out_not_ready  = out_nr_r;

endmodule

@@ hw/rtl/sbb_ctrl.sv @@
// sbb_ctrl: sequencer for load, drain and the row and column blur passes.
// Depends on sbb_pkg for the datapath command and status types.
module sbb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_operation,
  output logic                busy,
  output sbb_pkg::dp_cmd_t    cmd,
  input  sbb_pkg::dp_status_t st
);
  import sbb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_INIT,
    ST_SETUP,
    ST_MUL,
    ST_ACC,
    ST_DIVGO,
    ST_DIV,
    ST_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   vpass_r, vpass_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    vpass_nxt = vpass_r;
    cmd.op    = DP_NOP;
    cmd.vpass = vpass_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation) begin
            cmd.op    = DP_DRAIN;
            state_nxt = ST_DRAIN;
          end else begin
            cmd.op = DP_LOAD;
            if (st.load_last) begin
              vpass_nxt = 1'b0;
              state_nxt = ST_INIT;
            end
          end
        end
      end
      ST_DRAIN: begin
        cmd.op    = DP_EMIT;
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        cmd.op    = DP_INIT;
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.op    = DP_SETUP;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op    = DP_MUL;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = DP_ACC;
        if (st.acc_done) state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd.op    = DP_DIVGO;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!st.div_busy) state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.op = DP_WRITE;
        if (!st.pix_last) begin
          state_nxt = ST_SETUP;
        end else if (vpass_r) begin
          state_nxt = ST_IDLE;
        end else begin
          vpass_nxt = 1'b1;
          state_nxt = ST_INIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vpass_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vpass_r <= vpass_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

@@ hw/rtl/separable_box_blur_core.sv @@
// separable_box_blur_core: edge-normalized separable box blur, APB config port.
// A load leaves busy low, except the load that completes the frame.
// A drain reads the result store, then registers the result and strobes it on out_valid.
// The completing load holds busy through the row and column passes, paced per pixel by the
// one-tap-per-cycle store read of its in-bounds taps and the 13-step serial divider.
// Sync reset clears pointers and frame_ready; sizes go to 64x64, kernel 3; stores keep data.
module separable_box_blur_core #(
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [sbb_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                        out_valid,
  output logic [sbb_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                        out_last_pixel,
  output logic                        out_not_ready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbb_pkg::APB_AW-1:0]  paddr,
  input  logic [sbb_pkg::APB_DW-1:0]  pwdata,
  output logic [sbb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import sbb_pkg::*;

  logic [SIZE_CFG_W-1:0] width_r, height_r;
  logic [KS_W-1:0]       kernel_r;
  logic                  cfg_wr;
  dp_cmd_t               cmd;
  dp_status_t            st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      kernel_r <= RST_KERNEL_SIZE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  width_r  <= pwdata[SIZE_CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[SIZE_CFG_W-1:0];
        REG_KERNEL_SIZE:  kernel_r <= pwdata[KS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = APB_DW'(width_r);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(height_r);
      REG_KERNEL_SIZE:  prdata = APB_DW'(kernel_r);
      default:          prdata = '0;
    endcase
  end

  sbb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .busy         (busy),
    .cmd          (cmd),
    .st           (st)
  );

  sbb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .cfg_kernel     (kernel_r),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_pixel_out  (out_pixel_out),
    .out_last_pixel (out_last_pixel),
    .out_not_ready  (out_not_ready)
  );

  // a drain transaction produces its result on out_valid after the drain and emit states
  a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation |=> ##1 out_valid)
    else $error("drain result missing");

  // a load that does not finish the frame does not stall the input
  a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_operation && !st.load_last |=> !busy)
    else $error("plain load raised busy");

  // results are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

endmodule

@@ dv/separable_box_blur_core_test.sv @@
// Testbench for separable_box_blur_core: random frames loaded over the command port,
// blurred pixels drained and checked against a cycle-free shadow of the blur.
// Depends on sbb_pkg and the core RTL only.
`timescale 1ns / 100ps

localparam bit OP_LOAD  = 1'b0;
localparam bit OP_DRAIN = 1'b1;

typedef struct packed {
  logic [sbb_pkg::PIX_W-1:0] pixel;
  logic                      last;
  logic                      not_ready;
  logic                      known;
} blur_pixel_t;

// Shadow of the core: source, row-averaged and blurred frames plus the pointers.
class box_blur_shadow;
  localparam int MAX_W = sbb_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H = sbb_pkg::DEF_MAX_HEIGHT;

  bit [sbb_pkg::PIX_W-1:0] source_pix [MAX_W*MAX_H];
  bit [sbb_pkg::PIX_W-1:0] row_avg [MAX_W*MAX_H];
  bit [sbb_pkg::PIX_W-1:0] blurred_pix [MAX_W*MAX_H];
  bit                      blurred_known [MAX_W*MAX_H];
  int                      load_ptr;
  int                      drain_ptr;
  bit                      frame_ready;
  int                      frame_w;
  int                      frame_h;
  bit [sbb_pkg::KS_W-1:0]  kernel_reg;
  blur_pixel_t             pending_pixels [$];
  int                      failures;
  int                      pixels_checked;
  int                      frames_blurred;

  function new();
    frame_w    = sbb_pkg::RST_IMAGE_WIDTH;
    frame_h    = sbb_pkg::RST_IMAGE_HEIGHT;
    kernel_reg = sbb_pkg::RST_KERNEL_SIZE;
  endfunction

  // sizes saturate into 1..MAX when used, so keep them clamped here
  function void write_config(logic [1:0] idx, logic [31:0] value);
    case (idx)
      sbb_pkg::REG_IMAGE_WIDTH: begin
        frame_w = (value[6:0] == 0) ? 1 : ((value[6:0] > MAX_W) ? MAX_W : value[6:0]);
      end
      sbb_pkg::REG_IMAGE_HEIGHT: begin
        frame_h = (value[6:0] == 0) ? 1 : ((value[6:0] > MAX_H) ? MAX_H : value[6:0]);
      end
      sbb_pkg::REG_KERNEL_SIZE: begin
        kernel_reg = value[4:0];
      end
      default: ;
    endcase
  endfunction

  function void take_item(bit op, logic [sbb_pkg::PIX_W-1:0] pix);
    int          area;
    int          r;
    int          sum;
    int          taps;
    blur_pixel_t res;
    area = frame_w * frame_h;
    if (op == OP_LOAD) begin
      if (load_ptr < MAX_W * MAX_H) source_pix[load_ptr] = pix;
      load_ptr++;
      if (load_ptr >= area) begin
        r = kernel_reg >> 1;
        for (int y = 0; y < frame_h; y++) begin
          for (int x = 0; x < frame_w; x++) begin
            sum  = 0;
            taps = 0;
            for (int d = -r; d <= r; d++) begin
              if (x + d >= 0 && x + d < frame_w) begin
                sum += source_pix[y * frame_w + x + d];
                taps++;
              end
            end
            row_avg[y * frame_w + x] = 8'(sum / taps);
          end
        end
        for (int y = 0; y < frame_h; y++) begin
          for (int x = 0; x < frame_w; x++) begin
            sum  = 0;
            taps = 0;
            for (int d = -r; d <= r; d++) begin
              if (y + d >= 0 && y + d < frame_h) begin
                sum += row_avg[(y + d) * frame_w + x];
                taps++;
              end
            end
            blurred_pix[y * frame_w + x]   = 8'(sum / taps);
            blurred_known[y * frame_w + x] = 1'b1;
          end
        end
        load_ptr    = 0;
        drain_ptr   = 0;
        frame_ready = 1'b1;
        frames_blurred++;
      end
      return;
    end
    if (!frame_ready) begin
      res = '{pixel: '0, last: 1'b0, not_ready: 1'b1, known: 1'b1};
    end else begin
      if (drain_ptr >= area) drain_ptr = 0;
      // an entry no blur has written yet holds no defined pixel; flags still compare
      res.pixel     = blurred_pix[drain_ptr];
      res.known     = blurred_known[drain_ptr];
      res.not_ready = 1'b0;
      res.last      = (drain_ptr + 1 >= area);
      drain_ptr     = res.last ? 0 : drain_ptr + 1;
    end
    pending_pixels.push_back(res);
  endfunction

  function void check_pixel(logic [sbb_pkg::PIX_W-1:0] pixel, logic last, logic not_ready);
    blur_pixel_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected result pixel %0d last %0d not_ready %0d",
               $time, pixel, last, not_ready);
      failures++;
      return;
    end
    want = pending_pixels.pop_front();
    pixels_checked++;
    if (want.known && want.pixel !== pixel) begin
      $display("%0t: pixel_out expected %0d got %0d", $time, want.pixel, pixel);
      failures++;
    end
    if (want.last !== last) begin
      $display("%0t: last_pixel expected %0d got %0d", $time, want.last, last);
      failures++;
    end
    if (want.not_ready !== not_ready) begin
      $display("%0t: not_ready expected %0d got %0d", $time, want.not_ready, not_ready);
      failures++;
    end
  endfunction
endclass

module separable_box_blur_core_test;
  import sbb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEM_TARGET = 1250;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic                in_operation   = 1'b0;
  logic [PIX_W-1:0]    in_pixel_in    = '0;
  logic                out_valid;
  logic [PIX_W-1:0]    out_pixel_out;
  logic                out_last_pixel;
  logic                out_not_ready;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [APB_AW-1:0]   paddr          = '0;
  logic [APB_DW-1:0]   pwdata         = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  box_blur_shadow blur = new();
  int             items_sent  = 0;
  int             cycle_count = 0;
  bit             no_gaps     = 1'b0;

  separable_box_blur_core DUT (
    .clk, .rst_n, .start, .busy, .in_operation, .in_pixel_in,
    .out_valid, .out_pixel_out, .out_last_pixel, .out_not_ready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, blur.pending_pixels.size());
      $display("separable_box_blur_core_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) blur.check_pixel(out_pixel_out, out_last_pixel, out_not_ready);
  end

  // mostly no gap, some short, a few long; junk on the data lines meanwhile
  task automatic idle_gap();
    int n;
    int pick;
    pick = $urandom_range(99, 0);
    if (no_gaps || pick < 55) n = 0;
    else if (pick < 88) n = $urandom_range(3, 1);
    else if (pick < 97) n = $urandom_range(12, 4);
    else n = $urandom_range(60, 20);
    if (n == 0) return;
    start        <= 1'b0;
    in_operation <= 1'($urandom);
    in_pixel_in  <= 8'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // start stays high on return unless a gap was inserted, so a back-to-back transaction needs no re-raise
  task automatic issue_item(input bit op, input logic [PIX_W-1:0] pix);
    start        <= 1'b1;
    in_operation <= op;
    in_pixel_in  <= pix;
    do @(posedge clk); while (busy);
    blur.take_item(op, pix);
    items_sent++;
    idle_gap();
  endtask

  // sender holds off until every result is back and the blur pass is over
  task automatic settle();
    start <= 1'b0;
    while (blur.pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    blur.write_config(idx, value);
  endtask

  task automatic configure(input logic [6:0] w, input logic [6:0] h, input logic [4:0] k,
                           input bit [2:0] mask);
    logic [31:0] noise;
    settle();
    noise = $urandom;
    if (mask[0]) write_reg(REG_IMAGE_WIDTH, {noise[31:7], w});
    if (mask[1]) write_reg(REG_IMAGE_HEIGHT, {noise[31:7], h});
    if (mask[2]) write_reg(REG_KERNEL_SIZE, {noise[31:5], k});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [PIX_W-1:0] corner_pix [6] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd1};
    int               pick;
    int               area;
    int               loads;
    int               drains;
    int               phase;
    logic [6:0]       w;
    logic [6:0]       h;
    logic [4:0]       k;
    bit [2:0]         mask;
    bit               broken;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // nothing blurred yet: drains come back flagged
    issue_item(OP_DRAIN, 8'hFF);
    issue_item(OP_DRAIN, 8'h00);

    // 3x2 frame, radius wider than the frame; drain one past the end to wrap
    configure(7'd3, 7'd2, 5'd31, 3'b111);
    foreach (corner_pix[i]) issue_item(OP_LOAD, corner_pix[i]);
    repeat (7) issue_item(OP_DRAIN, 8'($urandom));

    // partial frame, then shrink below the load count: the next load finishes it
    repeat (3) issue_item(OP_LOAD, 8'($urandom));
    configure(7'd2, 7'd1, 5'd2, 3'b111);
    issue_item(OP_LOAD, 8'hA5);
    repeat (3) issue_item(OP_DRAIN, 8'h5A);

    // zero sizes saturate to 1x1; drain pointer is now past the end and restarts
    configure(7'd0, 7'd0, 5'd1, 3'b111);
    issue_item(OP_DRAIN, 8'h00);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99, 0);
      if (phase == 0) begin
        w = 7'd127;
        h = 7'd1;
        k = 5'd31;
      end else if (phase == 1) begin
        w = 7'd1;
        h = 7'd64;
        k = 5'd0;
      end else if (pick < 4) begin
        w = 7'($urandom_range(127, 64));
        h = 7'($urandom_range(2, 0));
        k = 5'($urandom_range(31, 0));
      end else if (pick < 8) begin
        w = 7'($urandom_range(2, 0));
        h = 7'($urandom_range(127, 64));
        k = 5'($urandom_range(31, 0));
      end else begin
        w = 7'($urandom_range(12, 0));
        h = 7'($urandom_range(12, 0));
        k = 5'($urandom_range(31, 0));
      end
      mask = (phase < 2 || $urandom_range(3, 0) != 0) ? 3'b111 : 3'($urandom_range(7, 0));
      configure(w, h, k, mask);
      no_gaps = ($urandom_range(3, 0) == 0);

      area   = blur.frame_w * blur.frame_h;
      loads  = (blur.load_ptr < area) ? area - blur.load_ptr : 1;
      broken = (phase >= 2 && $urandom_range(9, 0) == 0);
      // abandoned frame: the next setting decides where it completes
      if (broken && loads > 1) loads = $urandom_range(loads - 1, 1);
      repeat (loads) begin
        if ($urandom_range(19, 0) == 0) issue_item(OP_DRAIN, 8'($urandom));
        issue_item(OP_LOAD, 8'($urandom));
      end

      if ($urandom_range(9, 0) < 7) drains = area + $urandom_range(3, 0);
      else drains = $urandom_range(2 * area, 0);
      repeat (drains) issue_item(OP_DRAIN, 8'($urandom));
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("%0d transactions in %0d settings, %0d frames blurred, %0d pixels compared",
             items_sent, phase + 4, blur.frames_blurred, blur.pixels_checked);
    $display("sizes 0..127 (saturated), kernels 0..31, early drains, wraps, mid-frame resizes");
    if (blur.failures == 0) begin
      $display("separable_box_blur_core_test: clean");
    end else begin
      $display("separable_box_blur_core_test: errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/sbb_pkg.sv
hw/rtl/sbb_div.sv
hw/rtl/sbb_datapath.sv
hw/rtl/sbb_ctrl.sv
hw/rtl/separable_box_blur_core.sv
dv/separable_box_blur_core_test.sv
